@@ sv/vgmopl2_pkg.sv @@
// Shared types, opcodes and constants for the VGM OPL2 command parser.
// Used by every module of the block but the FIFO; depends on nothing.
package vgmopl2_pkg;

  localparam int CMD_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam logic [23:0] RATE_RESET = 24'd53333;

  localparam logic [7:0] OP_WAIT_NIB_HI = 8'h70;
  localparam logic [7:0] OP_WRITE       = 8'h5a;
  localparam logic [7:0] OP_WAIT16      = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC   = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL    = 8'h63;
  localparam logic [7:0] OP_END         = 8'h66;
  localparam logic [7:0] OP_DATA_BLOCK  = 8'h67;

  localparam logic [15:0] SAMPLES_NTSC = 16'd735;
  localparam logic [15:0] SAMPLES_PAL  = 16'd882;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_END   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_OPCODE     = 4'd0,
    PH_WR_REG     = 4'd1,
    PH_WR_VAL     = 4'd2,
    PH_WAIT_LO    = 4'd3,
    PH_WAIT_HI    = 4'd4,
    PH_BLK_COMPAT = 4'd5,
    PH_BLK_TYPE   = 4'd6,
    PH_BLK_SIZE   = 4'd7,
    PH_BLK_DATA   = 4'd8
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  chip_register;
    logic [7:0]  chip_value;
    logic [15:0] wait_samples;
    logic [7:0]  bad_opcode;
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] wait_ticks;
  } res_t;

endpackage

@@ sv/vgmopl2_fifo.sv @@
// Small register-based first-in first-out queue with push/full and pop/empty.
// Generic in width and depth; no package dependencies.
module vgmopl2_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ sv/vgmopl2_front.sv @@
// Byte-level parser: tracks the decoding phase and emits one command record
// per finished command into the command queue. Depends on vgmopl2_pkg.
module vgmopl2_front
  import vgmopl2_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] stream_byte,
  input  logic       cmd_full,
  output logic       cmd_push,
  output cmd_t       cmd
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic        accept;
  phase_t      op_phase;
  logic        op_push;
  cmd_t        op_cmd;

  assign accept = byte_valid && !cmd_full;

  always_comb begin
    op_phase = PH_OPCODE;
    op_push  = 1'b0;
    op_cmd   = '0;
    if (stream_byte[7:4] == OP_WAIT_NIB_HI[7:4]) begin
      op_push             = 1'b1;
      op_cmd.kind         = KIND_WAIT;
      op_cmd.wait_samples = {12'd0, stream_byte[3:0]} + 16'd1;
    end else begin
      unique case (stream_byte)
        OP_WRITE:      op_phase = PH_WR_REG;
        OP_WAIT16:     op_phase = PH_WAIT_LO;
        OP_DATA_BLOCK: op_phase = PH_BLK_COMPAT;
        OP_WAIT_NTSC: begin
          op_push             = 1'b1;
          op_cmd.kind         = KIND_WAIT;
          op_cmd.wait_samples = SAMPLES_NTSC;
        end
        OP_WAIT_PAL: begin
          op_push             = 1'b1;
          op_cmd.kind         = KIND_WAIT;
          op_cmd.wait_samples = SAMPLES_PAL;
        end
        OP_END: begin
          op_push     = 1'b1;
          op_cmd.kind = KIND_END;
        end
        default: begin
          op_push           = 1'b1;
          op_cmd.kind       = KIND_BAD;
          op_cmd.bad_opcode = stream_byte;
        end
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    skip_nxt  = skip_r;
    cmd_push  = 1'b0;
    cmd       = '0;
    if (accept) begin
      unique case (phase_r)
        PH_WR_REG: begin
          held_nxt  = stream_byte;
          phase_nxt = PH_WR_VAL;
        end
        PH_WR_VAL: begin
          phase_nxt         = PH_OPCODE;
          cmd_push          = 1'b1;
          cmd.kind          = KIND_WRITE;
          cmd.chip_register = held_r;
          cmd.chip_value    = stream_byte;
        end
        PH_WAIT_LO: begin
          held_nxt  = stream_byte;
          phase_nxt = PH_WAIT_HI;
        end
        PH_WAIT_HI: begin
          phase_nxt        = PH_OPCODE;
          cmd_push         = 1'b1;
          cmd.kind         = KIND_WAIT;
          cmd.wait_samples = {stream_byte, held_r};
        end
        PH_BLK_COMPAT: phase_nxt = PH_BLK_TYPE;
        PH_BLK_TYPE: begin
          idx_nxt   = 2'd0;
          skip_nxt  = '0;
          phase_nxt = PH_BLK_SIZE;
        end
        PH_BLK_SIZE: begin
          skip_nxt = skip_r | ({24'd0, stream_byte} << {idx_r, 3'b000});
          if (idx_r == 2'd3) begin
            idx_nxt   = 2'd0;
            phase_nxt = (skip_nxt == '0) ? PH_OPCODE : PH_BLK_DATA;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        PH_BLK_DATA: begin
          if (skip_r != '0) begin
            skip_nxt = skip_r - 32'd1;
          end
          if (skip_r <= 32'd1) begin
            phase_nxt = PH_OPCODE;
          end
        end
        PH_OPCODE: begin
          phase_nxt = op_phase;
          cmd_push  = op_push;
          cmd       = op_cmd;
        end
        default: begin
          phase_nxt = op_phase;
          cmd_push  = op_push;
          cmd       = op_cmd;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE;
      held_r  <= '0;
      idx_r   <= '0;
      skip_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

@@ sv/vgmopl2_back.sv @@
// Execution side: takes command records, converts wait lengths to timer ticks
// in one registered multiply stage and queues the results. Depends on
// vgmopl2_pkg and vgmopl2_fifo.
module vgmopl2_back
  import vgmopl2_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic [23:0] rate,
  input  logic        res_pop,
  output logic        res_empty,
  output res_t        res
);

  logic        stage_v_r, stage_v_nxt;
  cmd_t        stage_cmd_r;
  logic [31:0] stage_ticks_r;
  logic [39:0] product;
  logic        stage_ready;
  logic        res_full;
  logic        res_push;
  res_t        res_wdata;

  assign product     = {24'd0, cmd.wait_samples} * {16'd0, rate};
  assign stage_ready = !stage_v_r || !res_full;
  assign cmd_pop     = cmd_valid && stage_ready;
  assign res_push    = stage_v_r && !res_full;
  assign res_wdata   = '{cmd: stage_cmd_r, wait_ticks: stage_ticks_r};

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (stage_ready) begin
      stage_v_nxt = cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      stage_cmd_r   <= cmd;
      stage_ticks_r <= product[39:8];
    end
  end

  vgmopl2_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res),
    .empty (res_empty)
  );

endmodule

@@ sv/vgm_opl2_command_parser.sv @@
// Top level of the VGM OPL2 command parser: parser front, command queue and
// execution back. Depends on vgmopl2_pkg, vgmopl2_front, vgmopl2_fifo and
// vgmopl2_back.
//
// Usage: the command stream enters one byte per request on in_push/in_full.
// A byte is taken at every edge with in_push high and in_full low, so the
// block sustains one byte per cycle. Each finished command (register write,
// wait, end of data, unknown opcode) yields one result on the out_ ports,
// shown while out_empty is low and taken with out_pop. Operand bytes and
// data block bytes yield no result.
// Each result passes through the command queue and then the 16 x 24 tick
// multiplier stage before it appears in the result queue. Fields not used by
// a result kind read as zero.
// When the receiver stops popping, the result queue and then the command
// queue fill and in_full rises; nothing is dropped.
// Reset empties both queues, returns the parser to opcode state and loads
// the ticks-per-sample register with its default. cfg_we writes that register
// at once; write it only while no request is in flight.
module vgm_opl2_command_parser
  import vgmopl2_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_stream_byte,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_chip_register,
  output logic [7:0]  out_chip_value,
  output logic [15:0] out_wait_samples,
  output logic [31:0] out_wait_ticks,
  output logic [7:0]  out_bad_opcode,
  input  logic        cfg_we,
  input  logic [23:0] cfg_ticks_per_sample_q8
);

  logic [23:0] rate_r;
  logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t        front_cmd, queued_cmd;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_we) begin
      rate_r <= cfg_ticks_per_sample_q8;
    end
  end

  vgmopl2_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_push),
    .stream_byte (in_stream_byte),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (front_cmd)
  );

  vgmopl2_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (queued_cmd),
    .empty (cmd_empty)
  );

  vgmopl2_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (queued_cmd),
    .cmd_pop   (cmd_pop),
    .rate      (rate_r),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (res)
  );

  assign in_full           = cmd_full;
  assign out_result_kind   = res.cmd.kind;
  assign out_chip_register = res.cmd.chip_register;
  assign out_chip_value    = res.cmd.chip_value;
  assign out_wait_samples  = res.cmd.wait_samples;
  assign out_wait_ticks    = res.wait_ticks;
  assign out_bad_opcode    = res.cmd.bad_opcode;

endmodule

@@ sv/vgmopl2_checker.sv @@
// Port-level checks for the VGM OPL2 command parser, bound to its top level.
// Depends on vgmopl2_pkg and vgm_opl2_command_parser.
module vgmopl2_checker
  import vgmopl2_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic [7:0]  in_stream_byte,
  input logic        in_full,
  input logic        out_pop,
  input logic        out_empty,
  input logic [1:0]  out_result_kind,
  input logic [7:0]  out_chip_register,
  input logic [7:0]  out_chip_value,
  input logic [15:0] out_wait_samples,
  input logic [31:0] out_wait_ticks,
  input logic [7:0]  out_bad_opcode,
  input logic        cfg_we,
  input logic [23:0] cfg_ticks_per_sample_q8
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("Queues not empty after reset.");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_result_kind)
      && $stable(out_wait_ticks) && $stable(out_chip_value))
    else $error("Waiting result changed before it was popped.");

  a_no_ticks_off_wait: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_result_kind != KIND_WAIT |->
      out_wait_ticks == '0 && out_wait_samples == '0)
    else $error("Wait fields set on a result that is not a wait.");

  a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_result_kind != KIND_BAD |-> out_bad_opcode == '0)
    else $error("Bad opcode field set on a valid command.");

  a_short_wait_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_result_kind == KIND_WAIT && out_wait_samples == 16'd1
      && !cfg_we && !$past(cfg_we) && !$past(cfg_we, 2) |->
      out_wait_ticks[23:16] == '0 && out_wait_ticks[31:24] == '0)
    else $error("Tick count of a one-sample wait out of range.");

endmodule

bind vgm_opl2_command_parser vgmopl2_checker u_checker (.*);

@@ tb/sv/tb_vgm_opl2_command_parser.sv @@
// Self-checking testbench for vgm_opl2_command_parser: drives VGM byte streams,
// predicts every decoded command and checks the result queue in order.
// Depends on vgmopl2_pkg and the vgm_opl2_command_parser RTL.
module tb_vgm_opl2_command_parser
  import vgmopl2_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  chip_register;
    logic [7:0]  chip_value;
    logic [15:0] wait_samples;
    logic [31:0] wait_ticks;
    logic [7:0]  bad_opcode;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        in_full;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_chip_register;
  logic [7:0]  out_chip_value;
  logic [15:0] out_wait_samples;
  logic [31:0] out_wait_ticks;
  logic [7:0]  out_bad_opcode;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_ticks_per_sample_q8 = 24'h000000;

  // Predictor state.
  phase_t      p_phase = PH_OPCODE;
  logic [7:0]  p_held = 8'h00;
  logic [1:0]  p_idx = 2'd0;
  logic [31:0] p_skip = 32'd0;
  logic [23:0] p_rate = RATE_RESET;

  parse_result_t pending_cmds[$];
  parse_result_t seen_cmd;
  parse_result_t want_cmd;

  int send_idle_pct = 32;
  int recv_idle_pct = 63;
  int mismatches = 0;
  int cmds_checked = 0;
  int stream_items = 0;
  int rates_written = 0;
  int cycles = 0;

  vgm_opl2_command_parser dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_push                 (in_push),
    .in_stream_byte          (in_stream_byte),
    .in_full                 (in_full),
    .out_pop                 (out_pop),
    .out_empty               (out_empty),
    .out_result_kind         (out_result_kind),
    .out_chip_register       (out_chip_register),
    .out_chip_value          (out_chip_value),
    .out_wait_samples        (out_wait_samples),
    .out_wait_ticks          (out_wait_ticks),
    .out_bad_opcode          (out_bad_opcode),
    .cfg_we                  (cfg_we),
    .cfg_ticks_per_sample_q8 (cfg_ticks_per_sample_q8)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("vgm_opl2_command_parser: mismatch");
      $finish;
    end
  end

  function automatic parse_result_t wait_result(input logic [15:0] samples);
    parse_result_t r;
    logic [63:0] prod;
    prod = (64'(samples) * 64'(p_rate)) >> 8;
    r = '0;
    r.kind = KIND_WAIT;
    r.wait_samples = samples;
    r.wait_ticks = (prod > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    parse_result_t r;
    bit emit;
    r = '0;
    emit = 1'b0;
    stream_items++;
    case (p_phase)
      PH_WR_REG: begin
        p_held = b;
        p_phase = PH_WR_VAL;
      end
      PH_WR_VAL: begin
        p_phase = PH_OPCODE;
        r.kind = KIND_WRITE;
        r.chip_register = p_held;
        r.chip_value = b;
        emit = 1'b1;
      end
      PH_WAIT_LO: begin
        p_held = b;
        p_phase = PH_WAIT_HI;
      end
      PH_WAIT_HI: begin
        p_phase = PH_OPCODE;
        r = wait_result({b, p_held});
        emit = 1'b1;
      end
      PH_BLK_COMPAT: p_phase = PH_BLK_TYPE;
      PH_BLK_TYPE: begin
        p_idx = 2'd0;
        p_skip = 32'd0;
        p_phase = PH_BLK_SIZE;
      end
      PH_BLK_SIZE: begin
        p_skip = p_skip | (32'(b) << (8 * p_idx));
        if (p_idx == 2'd3) begin
          p_idx = 2'd0;
          p_phase = (p_skip == 32'd0) ? PH_OPCODE : PH_BLK_DATA;
        end else begin
          p_idx = p_idx + 2'd1;
        end
      end
      PH_BLK_DATA: begin
        if (p_skip > 32'd0) p_skip = p_skip - 32'd1;
        if (p_skip == 32'd0) p_phase = PH_OPCODE;
      end
      default: begin
        p_phase = PH_OPCODE;
        if (b[7:4] == OP_WAIT_NIB_HI[7:4]) begin
          r = wait_result(16'(b[3:0]) + 16'd1);
          emit = 1'b1;
        end else begin
          case (b)
            OP_WRITE:      p_phase = PH_WR_REG;
            OP_WAIT16:     p_phase = PH_WAIT_LO;
            OP_WAIT_NTSC: begin
              r = wait_result(SAMPLES_NTSC);
              emit = 1'b1;
            end
            OP_WAIT_PAL: begin
              r = wait_result(SAMPLES_PAL);
              emit = 1'b1;
            end
            OP_END: begin
              r.kind = KIND_END;
              emit = 1'b1;
            end
            OP_DATA_BLOCK: p_phase = PH_BLK_COMPAT;
            default: begin
              r.kind = KIND_BAD;
              r.bad_opcode = b;
              emit = 1'b1;
            end
          endcase
        end
      end
    endcase
    if (emit) pending_cmds.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input parse_result_t exp_r,
                                 input parse_result_t got_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at cycle %0d: expected kind=%0d reg=%h val=%h samples=%h ticks=%h bad=%h",
               what, cycles, exp_r.kind, exp_r.chip_register, exp_r.chip_value,
               exp_r.wait_samples, exp_r.wait_ticks, exp_r.bad_opcode);
      $display("  actual kind=%0d reg=%h val=%h samples=%h ticks=%h bad=%h",
               got_r.kind, got_r.chip_register, got_r.chip_value,
               got_r.wait_samples, got_r.wait_ticks, got_r.bad_opcode);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      seen_cmd.kind = kind_t'(out_result_kind);
      seen_cmd.chip_register = out_chip_register;
      seen_cmd.chip_value = out_chip_value;
      seen_cmd.wait_samples = out_wait_samples;
      seen_cmd.wait_ticks = out_wait_ticks;
      seen_cmd.bad_opcode = out_bad_opcode;
      if (pending_cmds.size() == 0) begin
        report_mismatch("Unexpected result", '0, seen_cmd);
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (seen_cmd.kind !== want_cmd.kind ||
            seen_cmd.chip_register !== want_cmd.chip_register ||
            seen_cmd.chip_value !== want_cmd.chip_value ||
            seen_cmd.wait_samples !== want_cmd.wait_samples ||
            seen_cmd.wait_ticks !== want_cmd.wait_ticks ||
            seen_cmd.bad_opcode !== want_cmd.bad_opcode) begin
          report_mismatch("Result mismatch", want_cmd, seen_cmd);
        end
      end
      cmds_checked++;
    end
    out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Returns at the edge that accepted the byte.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (in_full);
    decode_byte(b);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [23:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_ticks_per_sample_q8 <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    p_rate = v;
    rates_written++;
  endtask

  // Keeps a data block that was entered by stray bytes short.
  function automatic logic [7:0] tame_byte(input logic [7:0] b);
    if (p_phase == PH_BLK_SIZE) return (p_idx == 2'd0) ? {4'h0, b[3:0]} : 8'h00;
    return b;
  endfunction

  task automatic send_random_command();
    logic [7:0] cmd[$];
    logic [7:0] u;
    int pick;
    int size;
    int keep;
    while (p_phase != PH_OPCODE) send_byte(tame_byte(8'($urandom_range(0, 255))));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_byte(tame_byte(8'($urandom_range(0, 255))));
      return;
    end else if (pick < 37) begin
      cmd.push_back(OP_WRITE);
      cmd.push_back(8'($urandom_range(0, 255)));
      cmd.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 52) begin
      cmd.push_back(OP_WAIT_NIB_HI | 8'($urandom_range(0, 15)));
    end else if (pick < 67) begin
      cmd.push_back(OP_WAIT16);
      cmd.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      cmd.push_back(($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
    end else if (pick < 74) begin
      cmd.push_back(OP_WAIT_NTSC);
    end else if (pick < 81) begin
      cmd.push_back(OP_WAIT_PAL);
    end else if (pick < 86) begin
      cmd.push_back(OP_END);
    end else if (pick < 94) begin
      size = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
      cmd.push_back(OP_DATA_BLOCK);
      cmd.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : OP_END);
      cmd.push_back(8'($urandom_range(0, 255)));
      cmd.push_back(size[7:0]);
      cmd.push_back(size[15:8]);
      cmd.push_back(8'h00);
      cmd.push_back(8'h00);
      for (int i = 0; i < size; i++) cmd.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 7) == 0) begin
        u = 8'h00;
      end else begin
        do u = 8'($urandom_range(0, 255));
        while (u[7:4] == OP_WAIT_NIB_HI[7:4] || u == OP_WRITE || u == OP_WAIT16 ||
               u == OP_WAIT_NTSC || u == OP_WAIT_PAL || u == OP_END ||
               u == OP_DATA_BLOCK);
      end
      cmd.push_back(u);
    end
    keep = cmd.size();
    if (keep > 1 && $urandom_range(0, 9) == 0) keep = $urandom_range(1, keep - 1);
    for (int i = 0; i < keep; i++) send_byte(cmd[i]);
  endtask

  task automatic test_register_writes();
    send_byte(OP_WRITE); send_byte(8'h00); send_byte(8'h00);
    send_byte(OP_WRITE); send_byte(8'hFF); send_byte(8'hFF);
  endtask

  task automatic test_waits();
    send_byte(8'h70);
    send_byte(8'h7F);
    send_byte(OP_WAIT_NTSC);
    send_byte(OP_WAIT_PAL);
    send_byte(OP_WAIT16); send_byte(8'h00); send_byte(8'h00);
  endtask

  task automatic test_end_and_unknown();
    send_byte(OP_END);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_data_blocks();
    send_byte(OP_DATA_BLOCK); send_byte(OP_END); send_byte(8'h00);
    repeat (4) send_byte(8'h00);
    send_byte(OP_DATA_BLOCK); send_byte(8'hA5); send_byte(8'h01);
    send_byte(8'h01); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h66);
    send_byte(OP_END);
  endtask

  task automatic test_rate_extremes();
    write_rate(24'h000000);
    send_byte(OP_WAIT16); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h7F);
    write_rate(24'hFFFFFF);
    send_byte(OP_WAIT16); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h70);
  endtask

  task automatic test_random_stream(input int snd_pct, input int rcv_pct,
                                    input logic [23:0] rate, input int n_items);
    int target;
    write_rate(rate);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    target = stream_items + n_items;
    while (stream_items < target) begin
      send_random_command();
      if ($urandom_range(0, 149) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_writes();
    test_waits();
    test_end_and_unknown();
    test_data_blocks();
    test_rate_extremes();
    test_random_stream(32, 63, 24'($urandom_range(0, 24'hFFFFFF)), 505);
    test_random_stream(63, 32, 24'($urandom_range(1, 1024)), 505);
    test_random_stream(0, 0, RATE_RESET, 505);
    drain_results();
    if (pending_cmds.size() != 0) mismatches++;
    $display("Streamed %0d stream bytes and checked %0d decoded commands", stream_items,
             cmds_checked);
    $display("across %0d tick rate settings and three sender/receiver stall patterns",
             rates_written + 1);
    if (mismatches == 0) begin
      $display("vgm_opl2_command_parser: match");
    end else begin
      $display("vgm_opl2_command_parser: mismatch");
    end
    $finish;
  end

endmodule
